[design/crc8c_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8c_pkg: shared types and functions of the configurable CRC-8 block
// Holds the configuration bundle, register indexes and the per-byte CRC step.
// ----------------------------------------------------------------------------
package crc8c_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned CRC_W  = 8;
    localparam int unsigned IDX_W  = 2;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_POLYNOMIAL    = 2'd0,
        REG_INITIAL_VALUE = 2'd1,
        REG_MSB_FIRST     = 2'd2
    } cfg_index_t;

    localparam logic [CRC_W-1:0] POLY_RESET = 8'h07;
    localparam logic [CRC_W-1:0] INIT_RESET = 8'h00;
    localparam logic             MSBF_RESET = 1'b1;

    // Configuration bundle passed from the register file to the CRC core
    typedef struct packed {
        logic [CRC_W-1:0] polynomial;
        logic [CRC_W-1:0] initial_value;
        logic             msb_first;
    } crc_cfg_t;

    // Bit reversal of one byte (pure wiring)
    function automatic logic [CRC_W-1:0] reverse8(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        r = '0;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

    // One byte through the CRC: XOR in the byte, then eight bit steps
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0]  crc,
                                                 input logic [DATA_W-1:0] data,
                                                 input crc_cfg_t          cfg);
        logic [CRC_W-1:0] r;
        logic [CRC_W-1:0] rpoly;
        r     = crc ^ data;
        rpoly = reverse8(cfg.polynomial);
        for (int i = 0; i < DATA_W; i++) begin
            if (cfg.msb_first) begin
                r = r[CRC_W-1] ? ({r[CRC_W-2:0], 1'b0} ^ cfg.polynomial)
                               : {r[CRC_W-2:0], 1'b0};
            end else begin
                r = r[0] ? ({1'b0, r[CRC_W-1:1]} ^ rpoly)
                         : {1'b0, r[CRC_W-1:1]};
            end
        end
        return r;
    endfunction

endpackage

[design/crc8_configurable_bitwise.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_configurable_bitwise: CRC-8 with configurable polynomial, seed, order
//
//   port group | direction | contents
//   s_*        | in        | tdata = data_byte[7:0], tuser = first_byte,
//              |           | tlast = last_byte
//   m_*        | out       | tdata = crc_value[7:0], one word per last byte
//   cfg_*      | in        | 0 polynomial, 1 initial_value, 2 msb_first
//
// One word per cycle sustained while no stalled result holds a tlast word;
// a last byte's CRC goes from the input register through the CRC network
// into the result register. The CRC network is a single XOR tree per byte
// between those two registers.
// Reset is synchronous (aresetn low); the CRC register clears to zero and
// the configuration returns to poly 0x07, seed 0x00, MSB first.
// A stalled result holds the output register; words without tlast keep
// flowing past it, and a tlast word waits in the input register.
// ----------------------------------------------------------------------------
module crc8_configurable_bitwise (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [crc8c_pkg::DATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic                         s_tuser,  // [0] first_byte
    input  logic                         s_tlast,
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [crc8c_pkg::CRC_W-1:0]  m_tdata,  // [7:0] crc_value
    // configuration
    input  logic                         cfg_we,
    input  logic [crc8c_pkg::IDX_W-1:0]  cfg_index,
    input  logic [crc8c_pkg::CRC_W-1:0]  cfg_data
);
    import crc8c_pkg::*;

    crc_cfg_t          cfg_reg;
    logic              in_valid_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              in_first_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    logic [CRC_W-1:0]  out_data_reg;
    logic              out_free;
    logic              advance;
    logic [CRC_W-1:0]  crc_value;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.polynomial    <= POLY_RESET;
            cfg_reg.initial_value <= INIT_RESET;
            cfg_reg.msb_first     <= MSBF_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_POLYNOMIAL:    cfg_reg.polynomial    <= cfg_data;
                REG_INITIAL_VALUE: cfg_reg.initial_value <= cfg_data;
                REG_MSB_FIRST:     cfg_reg.msb_first     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Flow control: a word leaves the input register unless it carries a
    // result and the output register is still occupied
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    crc8c_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .data    (in_data_reg),
        .first   (in_first_reg),
        .cfg     (cfg_reg),
        .crc_out (crc_value)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance && in_last_reg) begin
            out_data_reg <= crc_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A tlast word never advances over an occupied, stalled result
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_last_reg && m_tvalid && !m_tready) |-> !advance)
        else $error("result overwritten while stalled");

    // A new result comes only from a tlast word that advanced
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(advance && in_last_reg))
        else $error("result without a last word");

    // The result register takes exactly the CRC of the advancing last word
    a_result_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg && out_free) |=> (m_tvalid && m_tdata == $past(crc_value)))
        else $error("result value mismatch");

endmodule

[design/crc8c_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8c_core: running CRC register and byte update network
// Folds one registered byte per enabled cycle into the running CRC.
// ----------------------------------------------------------------------------
module crc8c_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step_en,
    input  logic [crc8c_pkg::DATA_W-1:0] data,
    input  logic                         first,
    input  crc8c_pkg::crc_cfg_t          cfg,
    output logic [crc8c_pkg::CRC_W-1:0]  crc_out
);
    import crc8c_pkg::*;

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;

    // Seed on a first word, otherwise continue the running value
    always_comb begin
        crc_next = crc_byte(first ? cfg.initial_value : crc_reg, data, cfg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= '0;
        end else if (step_en) begin
            crc_reg <= crc_next;
        end
    end

    assign crc_out = crc_next;

endmodule

[bench/crc8_configurable_bitwise_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_configurable_bitwise_test: self-checking bench for the CRC-8 block
// Sends byte words with first/last marks under several polynomial, seed and
// bit-order settings, predicts each CRC word with an independent bit-serial
// model and compares it with what the block puts on the result stream. Both
// streams idle at random.
// ----------------------------------------------------------------------------
module crc8_configurable_bitwise_test;

    import crc8c_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned SHOWN_ERRORS = 10;
    localparam int unsigned PHASE_WORDS = 160;
    localparam int unsigned RANDOM_PHASES = 12;
    // index with no register behind it; writes there must be dropped
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct {
        logic [DATA_W-1:0] data_byte;
        bit                first_byte;
        bit                last_byte;
    } byte_word_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [CRC_W-1:0]  m_tdata;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CRC_W-1:0]  cfg_data = '0;

    // bench copy of the configuration and the running CRC register
    logic [CRC_W-1:0]  poly_cfg = POLY_RESET;
    logic [CRC_W-1:0]  seed_cfg = INIT_RESET;
    logic              msbf_cfg = MSBF_RESET;
    logic [CRC_W-1:0]  crc_state = '0;

    byte_word_t        byte_queue[$];
    logic [CRC_W-1:0]  crc_awaited[$];

    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count = 0;
    bit                word_done = 1'b0;
    bit                src_calm = 1'b0;
    bit                sink_calm = 1'b0;
    int unsigned       src_gap = 0;
    int unsigned       sink_stall = 0;

    crc8_configurable_bitwise dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] data_byte
        .s_tuser   (s_tuser),   // [0] first_byte
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [7:0] crc_value
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Bit-serial CRC update for one byte under the current settings
    function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                    input logic [DATA_W-1:0] value);
        logic [CRC_W-1:0] acc;
        logic [CRC_W-1:0] refl_poly;
        logic             carry;
        acc = crc ^ value;
        for (int k = 0; k < CRC_W; k++) begin
            refl_poly[CRC_W-1-k] = poly_cfg[k];
        end
        for (int step = 0; step < DATA_W; step++) begin
            if (msbf_cfg) begin
                carry = acc[CRC_W-1];
                acc = acc << 1;
                if (carry) acc = acc ^ poly_cfg;
            end else begin
                carry = acc[0];
                acc = acc >> 1;
                if (carry) acc = acc ^ refl_poly;
            end
        end
        return acc;
    endfunction

    // Mostly short idles, now and then a long one, none in calm stretches
    function automatic int unsigned idle_len(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    task automatic note_error(input string what, input logic [CRC_W-1:0] want,
                              input logic [CRC_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
            $display("[%0t] %s: expected %02h, got %02h", $realtime, what, want, got);
    endtask

    task automatic push_word(input logic [DATA_W-1:0] value, input bit first,
                             input bit last);
        byte_word_t w;
        w.data_byte = value;
        w.first_byte = first;
        w.last_byte = last;
        byte_queue.push_back(w);
    endtask

    // One message of random bytes, properly framed
    task automatic push_message(input int unsigned len);
        for (int unsigned n = 0; n < len; n++)
            push_word(8'($urandom_range(0, 255)), n == 0, n == len - 1);
    endtask

    // Register write at the falling edge, mirrored into the bench copy
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CRC_W-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POLYNOMIAL:    poly_cfg = value;
            REG_INITIAL_VALUE: seed_cfg = value;
            REG_MSB_FIRST:     msbf_cfg = value[0];
            default: ;
        endcase
    endtask

    // Block until every word is in, every CRC is out and the pipe is empty
    task automatic wait_idle();
        while (byte_queue.size() != 0 || s_tvalid || crc_awaited.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned r;
        int unsigned len;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 90) begin
                r = $urandom_range(0, 99);
                if (r < 80) len = $urandom_range(1, 8);
                else if (r < 98) len = $urandom_range(9, 24);
                else len = $urandom_range(40, 64);
                push_message(len);
                sent += len;
            end else begin
                // stray word with arbitrary marks
                push_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // Stimulus and configuration sequence
    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: unmarked start, one-byte messages, check string, restart
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hFF, 1'b0, 1'b1);
        push_word(8'hA5, 1'b0, 1'b1);
        push_word(8'h80, 1'b1, 1'b1);
        push_word(8'h01, 1'b1, 1'b1);
        push_word(8'h00, 1'b1, 1'b1);
        push_word(8'hFF, 1'b1, 1'b1);
        for (int unsigned c = 8'h31; c <= 8'h39; c++)
            push_word(c[7:0], c == 8'h31, c == 8'h39);
        push_word(8'h5A, 1'b1, 1'b0);
        push_word(8'hC3, 1'b0, 1'b0);
        push_word(8'h3C, 1'b1, 1'b1);
        push_word(8'h7E, 1'b0, 1'b0);
        wait_idle();

        // fixed corner settings, then random ones
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_POLYNOMIAL, 8'h00);
                    write_reg(REG_INITIAL_VALUE, 8'hFF);
                    write_reg(REG_MSB_FIRST, 8'hFE);
                end
                1: begin
                    write_reg(REG_POLYNOMIAL, 8'hFF);
                    write_reg(REG_INITIAL_VALUE, 8'h00);
                    write_reg(REG_UNMAPPED, 8'hFF);
                    write_reg(REG_MSB_FIRST, 8'h01);
                end
                2: begin
                    write_reg(REG_POLYNOMIAL, 8'h31);
                    write_reg(REG_INITIAL_VALUE, 8'hFF);
                    write_reg(REG_MSB_FIRST, 8'h00);
                end
                3: begin
                    write_reg(REG_POLYNOMIAL, 8'h1D);
                    write_reg(REG_MSB_FIRST, 8'hFF);
                end
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        write_reg(REG_UNMAPPED, 8'($urandom_range(0, 255)));
                    write_reg(REG_POLYNOMIAL, 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 3) != 0)
                        write_reg(REG_INITIAL_VALUE, 8'($urandom_range(0, 255)));
                    write_reg(REG_MSB_FIRST, 8'($urandom_range(0, 255)));
                end
            endcase
            // the first phases start with a few unframed words
            if (phase < 2) begin
                push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
            random_traffic(PHASE_WORDS);
            wait_idle();
        end

        repeat (2 * DRAIN_CYCLES) @(posedge aclk);
        if (crc_awaited.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Input driver: new word or idle at the falling edge
    always @(negedge aclk) begin
        byte_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_done) begin
            word_done = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
                w = byte_queue.pop_front();
                s_tdata <= w.data_byte;
                s_tuser <= w.first_byte;
                s_tlast <= w.last_byte;
                s_tvalid <= 1'b1;
                src_gap = idle_len(src_calm);
                if ($urandom_range(0, 99) == 0) src_calm = !src_calm;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            sink_stall = idle_len(sink_calm);
            if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
        end
    end

    // Monitor: check results, predict from accepted words, watch the clock
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (crc_awaited.size() == 0)
                    note_error("unexpected CRC word", '0, m_tdata);
                else if (crc_awaited[0] !== m_tdata)
                    note_error("crc_value mismatch", crc_awaited[0], m_tdata);
                if (crc_awaited.size() != 0) void'(crc_awaited.pop_front());
            end
            if (s_tvalid && s_tready) begin
                crc_state = crc_update(s_tuser ? seed_cfg : crc_state, s_tdata);
                if (s_tlast) crc_awaited.push_back(crc_state);
                word_done = 1'b1;
            end
        end
    end

endmodule

[filelist.f]
design/crc8c_pkg.sv
design/crc8c_core.sv
design/crc8_configurable_bitwise.sv
bench/crc8_configurable_bitwise_test.sv
